// ===== rtl/smva_pkg.sv =====
// Package with shared constants for the sample to millivolt ASCII frame unit.
`default_nettype none

package smva_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned GAIN_W   = 8;
  localparam int unsigned CHAR_W   = 8;

  // Width of the scaled value: the product of sample and gain, halved.
  localparam int unsigned VAL_W = SAMPLE_W + GAIN_W - 1;

  // Default number of decimal digits in a frame.
  localparam int unsigned DIGITS_DEF = 5;

  // Gain after reset.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd39;

  // Frame characters.
  localparam logic [CHAR_W-1:0] CHAR_FF   = 8'h0C;
  localparam logic [CHAR_W-1:0] CHAR_M    = 8'h6D;
  localparam logic [CHAR_W-1:0] CHAR_V    = 8'h56;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

endpackage

`default_nettype wire

// ===== rtl/smva_dabble_cell.sv =====
// One shift-and-add-3 cell of the binary to BCD conversion chain.
`default_nettype none

module smva_dabble_cell
  import smva_pkg::*;
#(
  parameter int unsigned DIGITS = DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [4*DIGITS-1:0]   bcd_i,
  input  logic [VAL_W-1:0]      bits_i,
  output logic                  valid_o,
  output logic [4*DIGITS-1:0]   bcd_o,
  output logic [VAL_W-1:0]      bits_o
);

  logic                valid_q;
  logic [4*DIGITS-1:0] bcd_q, bcd_d, adj;
  logic [VAL_W-1:0]    bits_q, bits_d;

  // Correct every digit that would pass nine after doubling, then shift in the next bit.
  // The carry out of the top digit is dropped, which keeps the value modulo 10^DIGITS.
  always_comb begin
    for (int unsigned k = 0; k < DIGITS; k++) begin
      if (bcd_i[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_i[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_i[4*k +: 4];
      end
    end
    bcd_d  = {adj[4*DIGITS-2:0], bits_i[VAL_W-1]};
    bits_d = {bits_i[VAL_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bcd_q  <= bcd_d;
      bits_q <= bits_d;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign bits_o  = bits_q;

endmodule

`default_nettype wire

// ===== rtl/smva_frame_tx.sv =====
// Frame serializer that sends form feed, the digits, 'm' and 'V' one byte at a time.
`default_nettype none

module smva_frame_tx
  import smva_pkg::*;
#(
  parameter int unsigned DIGITS = DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [4*DIGITS-1:0] bcd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CHAR_W-1:0]   char_out_o,
  output logic                last_o
);

  localparam int unsigned FRAME_LEN = DIGITS + 3;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  logic                busy_q, busy_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [4*DIGITS-1:0] bcd_q;
  logic                at_end, load;

  assign at_end     = (idx_q == IDX_W'(FRAME_LEN - 1));
  assign in_ready_o = !busy_q || (out_ready_i && at_end);
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q && out_ready_i) begin
      if (at_end) begin
        busy_d = 1'b0;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q <= bcd_i;
    end
  end

  // Byte select: the most significant digit goes out right after the form feed.
  always_comb begin
    char_out_o = CHAR_FF;
    for (int unsigned p = 0; p < DIGITS; p++) begin
      if (idx_q == IDX_W'(DIGITS - p)) begin
        char_out_o = CHAR_ZERO + {4'b0000, bcd_q[4*p +: 4]};
      end
    end
    if (idx_q == IDX_W'(DIGITS + 1)) begin
      char_out_o = CHAR_M;
    end
    if (at_end) begin
      char_out_o = CHAR_V;
    end
  end

  assign out_valid_o = busy_q;
  assign last_o      = at_end;

endmodule

`default_nettype wire

// ===== rtl/sample_to_millivolt_ascii_frame_unit.sv =====
// Top level of the sample to millivolt ASCII frame unit.
`default_nettype none

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+--------------------------
// input     | in        | in_valid_i / in_ready_o   | sample_i [7:0]
// output    | out       | out_valid_o / out_ready_i | char_out_o [7:0], last_o
// config    | in        | cfg_valid_i / cfg_ready_o | cfg_gain_i [7:0]
//
// Each sample produces a frame of DIGITS + 3 bytes, one byte per cycle while out_ready_i
// is high, so the frame serializer sets the rate at which new samples are taken.
// A sample passes through one multiply stage and then a chain of VAL_W conversion
// cells, each of which handles one bit of the scaled value, before the serializer.
// The whole chain stalls together when its last cell holds a result and the serializer
// cannot take it. Reset clears all valid flags and sets the gain to 39.

module sample_to_millivolt_ascii_frame_unit
  import smva_pkg::*;
#(
  parameter int unsigned DIGITS = DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CHAR_W-1:0]   char_out_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [GAIN_W-1:0]   cfg_gain_i
);

  // Gain register. Writes must only happen while the unit is idle; the block does not enforce this and is always ready.
  logic [GAIN_W-1:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_gain_i;
    end
  end

  // Global advance of the conversion chain.
  logic                tx_ready;
  logic                adv;
  logic                chain_valid [VAL_W+1];
  logic [4*DIGITS-1:0] chain_bcd   [VAL_W+1];
  logic [VAL_W-1:0]    chain_bits  [VAL_W+1];

  assign adv        = !chain_valid[VAL_W] || tx_ready;
  assign in_ready_o = adv;

  // Multiply stage: the product is halved by dropping its lowest bit.
  logic                       mul_valid_q;
  logic [VAL_W-1:0]           mul_val_q;
  logic [SAMPLE_W+GAIN_W-1:0] product;

  assign product = {{GAIN_W{1'b0}}, sample_i} * {{SAMPLE_W{1'b0}}, gain_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (adv) begin
      mul_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_val_q <= product[SAMPLE_W+GAIN_W-1:1];
    end
  end

  assign chain_valid[0] = mul_valid_q;
  assign chain_bcd[0]   = '0;
  assign chain_bits[0]  = mul_val_q;

  // One cell per bit of the scaled value, most significant bit first.
  for (genvar g = 0; g < VAL_W; g++) begin : g_cell
    smva_dabble_cell #(
      .DIGITS (DIGITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (chain_valid[g]),
      .bcd_i   (chain_bcd[g]),
      .bits_i  (chain_bits[g]),
      .valid_o (chain_valid[g+1]),
      .bcd_o   (chain_bcd[g+1]),
      .bits_o  (chain_bits[g+1])
    );
  end

  // The serializer holds the finished digits, so a new sample can enter while a
  // frame is still being sent.
  smva_frame_tx #(
    .DIGITS (DIGITS)
  ) u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[VAL_W]),
    .in_ready_o  (tx_ready),
    .bcd_i       (chain_bcd[VAL_W]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_out_o  (char_out_o),
    .last_o      (last_o)
  );

  // An accepted sample always lands in the multiply stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> mul_valid_q)
    else $error("accepted sample did not reach the multiply stage");

  // A finished conversion waiting on the serializer is held, not lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[VAL_W] && !tx_ready |=> chain_valid[VAL_W] && $stable(chain_bcd[VAL_W]))
    else $error("conversion result dropped during a stall");

  // The end-of-frame mark only ever sits on the 'V' byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> char_out_o == CHAR_V)
    else $error("frame end marked on a byte other than V");

endmodule

`default_nettype wire

// ===== dv/smva_frame_checker.sv =====
// Checker that predicts and compares the ASCII millivolt frames of the unit.
`timescale 1ns / 100ps

module smva_frame_checker
  import smva_pkg::*;
#(
  parameter int unsigned DIGITS = DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [CHAR_W-1:0]   char_out_i,
  input  logic                last_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [GAIN_W-1:0]   cfg_gain_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } frame_byte_t;

  frame_byte_t       expected_bytes[$];
  logic [GAIN_W-1:0] gain_q;
  int                fail_count;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    fail_count   = 0;
  end

  // Scale one sample to millivolts and queue the whole frame it produces.
  task automatic push_millivolt_frame(input logic [SAMPLE_W-1:0] sample,
                                      input logic [GAIN_W-1:0] gain);
    int unsigned millivolts;
    int unsigned digit_val[DIGITS];
    frame_byte_t fb;
    millivolts = (int'(sample) * int'(gain)) / 2;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      digit_val[i] = millivolts % 10;
      millivolts   = millivolts / 10;
    end
    fb.char_out = CHAR_FF;
    fb.last     = 1'b0;
    expected_bytes.push_back(fb);
    for (int i = 0; i < DIGITS; i++) begin
      fb.char_out = CHAR_ZERO + CHAR_W'(digit_val[i]);
      expected_bytes.push_back(fb);
    end
    fb.char_out = CHAR_M;
    expected_bytes.push_back(fb);
    fb.char_out = CHAR_V;
    fb.last     = 1'b1;
    expected_bytes.push_back(fb);
  endtask

  task automatic note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  // The output side is handled before the input side so that a byte seen at
  // the same edge as a new sample is never matched against that sample.
  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t want;
    if (!rst_ni) begin
      expected_bytes.delete();
      gain_q    <= GAIN_RESET;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected byte char_out=%02h last=%0b",
                                  char_out_i, last_i));
        end else begin
          want = expected_bytes.pop_front();
          if (char_out_i !== want.char_out || last_i !== want.last) begin
            note_mismatch($sformatf("expected char_out=%02h last=%0b, got char_out=%02h last=%0b",
                                    want.char_out, want.last, char_out_i, last_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) push_millivolt_frame(sample_i, gain_q);
      if (cfg_valid_i && cfg_ready_i) gain_q <= cfg_gain_i;
      pending_o <= expected_bytes.size();
    end
    fail_count_o <= fail_count;
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the testbench for the sample to millivolt ASCII frame unit.
`timescale 1ns / 100ps

module tb_top;
  import smva_pkg::*;

  localparam int unsigned RESET_CYCLES     = 8;
  // Pipeline depth plus one whole frame, with margin.
  localparam int unsigned SETTLE_CYCLES    = VAL_W + 2 + DIGITS_DEF + 3 + 16;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned RANDOM_PHASES    = 5;
  localparam int unsigned ITEMS_PER_PHASE  = 30;
  localparam int unsigned HOLD_PHASE       = 2;

  // Output stall styles; each lasts a random number of cycles.
  typedef enum int unsigned {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_RHYTHM
  } rx_style_e;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAR_W-1:0]   char_out;
  logic                last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [GAIN_W-1:0]   cfg_gain  = '0;

  int          fail_count;
  int          frames_pending;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  logic        hold_req    = 1'b0;

  sample_to_millivolt_ascii_frame_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .char_out_o  (char_out),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_gain_i  (cfg_gain)
  );

  // The checker watches all three channels and keeps its own gain copy.
  smva_frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .char_out_i   (char_out),
    .last_i       (last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_gain_i   (cfg_gain),
    .fail_count_o (fail_count),
    .pending_o    (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost byte ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver. It changes its stall style at random intervals, and on
  // request it holds off for a long stretch so that the pipeline fills and
  // the input side stalls while the sender keeps offering samples.
  initial begin : receiver
    rx_style_e   rx_style;
    int unsigned style_left;
    int unsigned hold_left;
    int unsigned rhythm;
    rx_style   = RX_STEADY;
    style_left = 0;
    hold_left  = 0;
    rhythm     = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          rx_style   = rx_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        rhythm++;
        case (rx_style)
          RX_STEADY: begin
            out_ready <= 1'b1;
          end
          RX_COIN: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          RX_SPARSE: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready <= (rhythm % 3 != 0);
          end
        endcase
      end
    end
  end

  // Offer one sample and wait for its transaction. Valid stays high into the
  // next sample unless a gap between bursts starts here.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit gaps_on);
    int unsigned gap;
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(1, 10);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stop offering samples until every expected byte has come back, then let
  // the pipeline settle so a gain write lands on an idle block.
  task automatic wait_frames_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_gain  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly uniform samples, with the edges of the range mixed in.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return SAMPLE_W'(1);
        default: return SAMPLE_W'(254);
      endcase
    end
    return SAMPLE_W'($urandom);
  endfunction

  initial begin : stimulus
    logic [SAMPLE_W-1:0] directed_q[$];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part with the gain left at its reset value: both ends of the
    // sample range and alternating bit patterns.
    directed_q = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h02, 8'hFE};
    foreach (directed_q[i]) send_sample(directed_q[i], 1'b1);
    wait_frames_drained();

    // Largest gain: full-scale sample gives the widest value, 32512 mV.
    write_gain(8'hFF);
    directed_q = '{8'hFF, 8'hFE, 8'h00, 8'h01, 8'h80, 8'h7F};
    foreach (directed_q[i]) send_sample(directed_q[i], 1'b1);
    wait_frames_drained();

    // Zero gain: every frame reads all zeros.
    write_gain(8'h00);
    directed_q = '{8'hFF, 8'hA5};
    foreach (directed_q[i]) send_sample(directed_q[i], 1'b1);
    wait_frames_drained();

    // Unity gain: odd products check that halving truncates.
    write_gain(8'h01);
    directed_q = '{8'h01, 8'h03, 8'hFF};
    foreach (directed_q[i]) send_sample(directed_q[i], 1'b1);
    wait_frames_drained();

    // Random part: a fresh gain per phase. In one phase the receiver holds
    // off for a long stretch while samples arrive back to back.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_gain(GAIN_W'($urandom));
      if (phase == HOLD_PHASE) hold_req <= 1'b1;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_sample(pick_sample(), phase != HOLD_PHASE);
      end
      wait_frames_drained();
    end

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
